[sv/osr_pkg.sv]
// shared types, codes and constants for the ordered slot registry
`default_nettype none

package osr_pkg;

    // defaults for the top level parameters
    localparam int NODE_LIMIT_DEF = 12;
    localparam int HALF_SLOTS_DEF = 6;

    // slot index width covers a table of up to MAX_SLOTS slots
    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);

    // fixed field widths
    localparam int ACTION_W = 2;
    localparam int NODE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 4;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_REGISTER = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [NODE_W-1:0]   node_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                is_member;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  occupied_count;
        logic                active;
    } rsp_t;

    // record that walks down the cell chain
    typedef struct packed {
        logic                valid;
        logic [ACTION_W-1:0] action;
        logic [NODE_W-1:0]   node_id;
        logic                hit;
        logic [SLOT_W-1:0]   hit_pos;
        logic                free_found;
        logic [SLOT_W-1:0]   free_pos;
    } scan_t;

    // slot update broadcast to every cell
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [SLOT_W-1:0] idx;
        logic [NODE_W-1:0] node_id;
    } commit_t;

endpackage

`default_nettype wire

[sv/osr_cell.sv]
// one registry slot with its stage of the scan chain
`default_nettype none

module osr_cell import osr_pkg::*; #(
    parameter int NODE_LIMIT = NODE_LIMIT_DEF,
    parameter int CELL_IDX   = 0
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  scan_t     scan_in,
    output scan_t     scan_out,
    input  commit_t   commit
);

    localparam int ID_W = $clog2(NODE_LIMIT);
    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_IDX);

    logic [ID_W-1:0] id_reg, id_next;
    logic            used_reg, used_next;
    scan_t           scan_reg, scan_next;
    logic            match;
    logic            sel;

    assign match = used_reg && (NODE_W'(id_reg) == scan_in.node_id);
    assign sel   = (commit.idx == MY_IDX);

    always_comb
    begin
        scan_next = scan_in;
        // keep the lowest matching and the lowest free slot
        if (!scan_in.hit && match)
        begin
            scan_next.hit     = 1'b1;
            scan_next.hit_pos = MY_IDX;
        end
        if (!scan_in.free_found && !used_reg)
        begin
            scan_next.free_found = 1'b1;
            scan_next.free_pos   = MY_IDX;
        end
    end

    always_comb
    begin
        id_next   = id_reg;
        used_next = used_reg;
        if (commit.set && sel)
        begin
            used_next = 1'b1;
            id_next   = ID_W'(commit.node_id);
        end
        else if (commit.clr && sel)
        begin
            used_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            scan_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            scan_reg <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign scan_out = scan_reg;

endmodule

`default_nettype wire

[sv/osr_ctrl.sv]
// request decision, occupancy count and result register
`default_nettype none

module osr_ctrl import osr_pkg::*; #(
    parameter int NODE_LIMIT = NODE_LIMIT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  scan_t     scan,
    output commit_t   commit,
    output logic      done,
    output rsp_t      rsp
);

    localparam int CNT_W = $clog2(NODE_LIMIT + 1);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                busy_reg, busy_next;
    logic                done_reg;
    rsp_t                rsp_reg, rsp_next;
    logic                in_range;
    logic [STATUS_W-1:0] status;
    logic                member;
    logic [SLOT_W-1:0]   pos;

    assign in_range = scan.node_id < NODE_W'(NODE_LIMIT);

    always_comb
    begin
        status         = ST_OK;
        member         = 1'b0;
        pos            = '0;
        count_next     = count_reg;
        commit         = '0;
        commit.node_id = scan.node_id;
        if (!in_range)
        begin
            status = ST_RANGE;
        end
        else
        begin
            case (scan.action)
                ACT_REGISTER:
                begin
                    if (scan.hit)
                    begin
                        status = ST_DUP;
                        member = 1'b1;
                        pos    = scan.hit_pos;
                    end
                    else if (count_reg >= CNT_W'(NODE_LIMIT) || !scan.free_found)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        member     = 1'b1;
                        pos        = scan.free_pos;
                        commit.set = scan.valid;
                        commit.idx = scan.free_pos;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_REMOVE:
                begin
                    if (!scan.hit)
                    begin
                        status = ST_MISSING;
                    end
                    else
                    begin
                        pos        = scan.hit_pos;
                        commit.clr = scan.valid;
                        commit.idx = scan.hit_pos;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    // query, and the unused code behaves the same
                    if (scan.hit)
                    begin
                        member = 1'b1;
                        pos    = scan.hit_pos;
                    end
                    else
                    begin
                        status = ST_MISSING;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_next.status         = status;
        rsp_next.is_member      = member;
        rsp_next.position       = POS_W'(pos);
        rsp_next.occupied_count = COUNT_W'(count_next);
        rsp_next.active         = (count_next != '0);
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (scan.valid)
        begin
            busy_next = 1'b0;
        end
        else if (start && !busy_reg)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= scan.valid;
            if (scan.valid)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan.valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

[sv/ordered_slot_registry.sv]
// ordered slot registry top level: cell chain and request controller
// one transaction at a time: busy blocks a new start while the scan walks one cell
//   per cycle down the slot chain and then commits the slot update
// reset: asynchronous active-low, every slot free, count zero, no transaction in flight
// results are shown for one cycle on done; the receiver cannot stall them
`default_nettype none

module ordered_slot_registry import osr_pkg::*; #(
    parameter int NODE_LIMIT = NODE_LIMIT_DEF,
    parameter int HALF_SLOTS = HALF_SLOTS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  req_t      req,
    output logic      done,
    output rsp_t      rsp
);

    // right half is slots 0 .. HALF_SLOTS-1, left half follows
    localparam int TOTAL_SLOTS = 2 * HALF_SLOTS;

    // chain[i] feeds cell i; chain[TOTAL_SLOTS] is the finished scan
    scan_t   chain [0:TOTAL_SLOTS];
    scan_t   launch;
    commit_t commit;

    // launch a fresh scan record into the first cell on an accepted transaction
    always_comb
    begin
        launch            = '0;
        launch.valid      = start && !busy;
        launch.action     = req.action;
        launch.node_id    = req.node_id;
        launch.hit        = 1'b0;
        launch.free_found = 1'b0;
    end

    assign chain[0] = launch;

    // each cell checks its own slot and hands the record on next cycle
    genvar gi;
    generate
        for (gi = 0; gi < TOTAL_SLOTS; gi++)
        begin : g_cell
            osr_cell #(
                .NODE_LIMIT (NODE_LIMIT),
                .CELL_IDX   (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .scan_in  (chain[gi]),
                .scan_out (chain[gi+1]),
                .commit   (commit)
            );
        end
    endgenerate

    // decide on the finished scan, update at most one slot and register the result
    osr_ctrl #(
        .NODE_LIMIT (NODE_LIMIT)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .scan   (chain[TOTAL_SLOTS]),
        .commit (commit),
        .done   (done),
        .rsp    (rsp)
    );

endmodule

`default_nettype wire
